// ===== hw/rtl/scc_pkg.sv =====
// Shared types, widths and helpers of the stencil CSR column generator.
package scc_pkg;

  localparam int unsigned MaxDim      = 256;
  localparam int unsigned EntriesPerRow = 7;

  localparam int unsigned SizeW   = 9;
  localparam int unsigned CoordW  = 9;
  localparam int unsigned ColW    = 24;
  localparam int unsigned PosW    = 27;
  localparam int unsigned PlaneW  = 17;
  localparam int unsigned TotalW  = ColW + 1;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = SizeW;

  localparam int unsigned Div1Steps = ColW;
  localparam int unsigned Div2Steps = 16;
  localparam int unsigned StepCntW  = $clog2(Div1Steps);

  typedef enum logic [CfgIdxW-1:0] {
    REG_SIZE_X     = 3'd0,
    REG_SIZE_Y     = 3'd1,
    REG_SIZE_Z     = 3'd2,
    REG_PERIODIC_X = 3'd3,
    REG_PERIODIC_Y = 3'd4,
    REG_PERIODIC_Z = 3'd5
  } cfg_reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL1,
    ST_MUL2,
    ST_CHECK,
    ST_DIV1,
    ST_MID,
    ST_DIV2,
    ST_BUILD,
    ST_EMIT
  } state_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_MUL1,
    OP_MUL2,
    OP_CHECK,
    OP_DIV_STEP,
    OP_DIV2_INIT,
    OP_BUILD,
    OP_POP
  } op_e;

  typedef struct packed {
    op_e op;
  } cmd_t;

  typedef struct packed {
    logic out_of_range;
    logic last;
  } sts_t;

  function automatic logic [SizeW-1:0] eff_size(input logic [SizeW-1:0] s);
    logic [SizeW-1:0] r;
    if (s == '0) begin
      r = SizeW'(1);
    end else if (s > SizeW'(MaxDim)) begin
      r = SizeW'(MaxDim);
    end else begin
      r = s;
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/scc_in_if.sv =====
// Input channel carrying one cell index per item.
interface scc_in_if import scc_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [ColW-1:0] cell_index;

  modport source (output valid, output cell_index, input ready);
  modport sink   (input valid, input cell_index, output ready);
endinterface

// ===== hw/rtl/scc_out_if.sv =====
// Output channel carrying one CSR column entry per item.
interface scc_out_if import scc_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [ColW-1:0] neighbour_column;
  logic [PosW-1:0] entry_position;
  logic            row_last;

  modport source (output valid, output neighbour_column, output entry_position,
                  output row_last, input ready);
  modport sink   (input valid, input neighbour_column, input entry_position,
                  input row_last, output ready);
endinterface

// ===== hw/rtl/scc_ctrl.sv =====
// Sequencing state machine of the stencil CSR column generator.
module scc_ctrl import scc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e                state_q, state_d;
  logic [StepCntW-1:0]   cnt_q, cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    cmd_o.op    = OP_NONE;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          state_d  = ST_MUL1;
        end
      end
      ST_MUL1: begin
        cmd_o.op = OP_MUL1;
        state_d  = ST_MUL2;
      end
      ST_MUL2: begin
        cmd_o.op = OP_MUL2;
        state_d  = ST_CHECK;
      end
      ST_CHECK: begin
        cmd_o.op = OP_CHECK;
        cnt_d    = '0;
        state_d  = sts_i.out_of_range ? ST_IDLE : ST_DIV1;
      end
      ST_DIV1: begin
        cmd_o.op = OP_DIV_STEP;
        cnt_d    = cnt_q + 1'b1;
        if (cnt_q == StepCntW'(Div1Steps - 1)) begin
          state_d = ST_MID;
        end
      end
      ST_MID: begin
        cmd_o.op = OP_DIV2_INIT;
        cnt_d    = '0;
        state_d  = ST_DIV2;
      end
      ST_DIV2: begin
        cmd_o.op = OP_DIV_STEP;
        cnt_d    = cnt_q + 1'b1;
        if (cnt_q == StepCntW'(Div2Steps - 1)) begin
          state_d = ST_BUILD;
        end
      end
      ST_BUILD: begin
        cmd_o.op = OP_BUILD;
        state_d  = ST_EMIT;
      end
      ST_EMIT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          cmd_o.op = OP_POP;
          if (sts_i.last) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== hw/rtl/scc_datapath.sv =====
// Configuration, divider, neighbour arithmetic and column sorter.
module scc_datapath import scc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic [ColW-1:0]     cell_index_i,
  input  cmd_t                cmd_i,
  output sts_t                sts_o,
  output logic [ColW-1:0]     column_o,
  output logic [PosW-1:0]     position_o
);

  logic [SizeW-1:0] size_x_q, size_y_q, size_z_q;
  logic             per_x_q, per_y_q, per_z_q;

  logic [SizeW-1:0]   nx, ny, nz;
  logic [ColW-1:0]    cell_q;
  logic [PlaneW-1:0]  nxny_q, nxny_m_nx_q;
  logic [TotalW-1:0]  total_q, tot_m_nxny_q;
  logic [CoordW-1:0]  rem_q, div_q, x_q;
  logic [ColW-1:0]    dq_q;
  logic [ColW-1:0]    cand_q [EntriesPerRow];
  logic [EntriesPerRow-1:0] valid_q, valid_d;
  logic [PosW-1:0]    entry_count_q;

  logic [CoordW:0]    trial;
  logic               trial_ge;
  logic [CoordW-1:0]  rem_next;
  logic [CoordW-1:0]  y, z;
  logic [TotalW-1:0]  c, n_x, n_xy, nxny_m_nx, tot_m_nxny;
  logic [TotalW-1:0]  cand [EntriesPerRow];
  logic [EntriesPerRow-1:0] cand_ok;
  logic [ColW-1:0]    best;
  logic               found;
  logic [EntriesPerRow-1:0] hit;

  assign nx = eff_size(size_x_q);
  assign ny = eff_size(size_y_q);
  assign nz = eff_size(size_z_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_x_q <= SizeW'(64);
      size_y_q <= SizeW'(64);
      size_z_q <= SizeW'(64);
      per_x_q  <= 1'b0;
      per_y_q  <= 1'b0;
      per_z_q  <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_SIZE_X:     size_x_q <= cfg_data_i;
        REG_SIZE_Y:     size_y_q <= cfg_data_i;
        REG_SIZE_Z:     size_z_q <= cfg_data_i;
        REG_PERIODIC_X: per_x_q  <= cfg_data_i[0];
        REG_PERIODIC_Y: per_y_q  <= cfg_data_i[0];
        REG_PERIODIC_Z: per_z_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // one restoring division step
  assign trial    = {rem_q, dq_q[ColW-1]};
  assign trial_ge = trial >= {1'b0, div_q};
  assign rem_next = trial_ge ? CoordW'(trial - {1'b0, div_q}) : trial[CoordW-1:0];

  // neighbour candidates
  assign y          = rem_q;
  assign z          = {1'b0, dq_q[7:0]};
  assign c          = {1'b0, cell_q};
  assign n_x        = TotalW'(nx);
  assign n_xy       = TotalW'(nxny_q);
  assign nxny_m_nx  = TotalW'(nxny_m_nx_q);
  assign tot_m_nxny = tot_m_nxny_q;

  always_comb begin
    cand[0] = (x_q == '0) ? c + n_x - TotalW'(1) : c - TotalW'(1);
    cand[1] = (x_q == nx - 1'b1) ? c - (n_x - TotalW'(1)) : c + TotalW'(1);
    cand[2] = (y == '0) ? c + nxny_m_nx : c - n_x;
    cand[3] = (y == ny - 1'b1) ? c - nxny_m_nx : c + n_x;
    cand[4] = (z == '0) ? c + tot_m_nxny : c - n_xy;
    cand[5] = (z == nz - 1'b1) ? c - tot_m_nxny : c + n_xy;
    cand[6] = c;
    cand_ok[0] = (x_q != '0) || per_x_q;
    cand_ok[1] = (x_q != nx - 1'b1) || per_x_q;
    cand_ok[2] = (y != '0) || per_y_q;
    cand_ok[3] = (y != ny - 1'b1) || per_y_q;
    cand_ok[4] = (z != '0) || per_z_q;
    cand_ok[5] = (z != nz - 1'b1) || per_z_q;
    cand_ok[6] = 1'b1;
  end

  // smallest pending column, and every copy of it
  always_comb begin
    best  = '1;
    found = 1'b0;
    for (int i = 0; i < EntriesPerRow; i++) begin
      if (valid_q[i] && (!found || cand_q[i] < best)) begin
        best  = cand_q[i];
        found = 1'b1;
      end
    end
    for (int i = 0; i < EntriesPerRow; i++) begin
      hit[i] = valid_q[i] && (cand_q[i] == best);
    end
  end

  always_comb begin
    valid_d = valid_q;
    if (cmd_i.op == OP_BUILD) begin
      valid_d = cand_ok;
    end else if (cmd_i.op == OP_POP) begin
      valid_d = valid_q & ~hit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q       <= '0;
      entry_count_q <= '0;
    end else begin
      valid_q <= valid_d;
      if (cmd_i.op == OP_POP) begin
        entry_count_q <= entry_count_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      OP_LOAD: cell_q <= cell_index_i;
      OP_MUL1: nxny_q <= PlaneW'(nx) * PlaneW'(ny);
      OP_MUL2: begin
        total_q     <= TotalW'(nxny_q) * TotalW'(nz);
        nxny_m_nx_q <= nxny_q - PlaneW'(nx);
      end
      OP_CHECK: begin
        tot_m_nxny_q <= total_q - TotalW'(nxny_q);
        rem_q        <= '0;
        dq_q         <= cell_q;
        div_q        <= nx;
      end
      OP_DIV_STEP: begin
        rem_q <= rem_next;
        dq_q  <= {dq_q[ColW-2:0], trial_ge};
      end
      OP_DIV2_INIT: begin
        x_q   <= rem_q;
        rem_q <= '0;
        dq_q  <= {dq_q[15:0], 8'h00};
        div_q <= ny;
      end
      OP_BUILD: begin
        for (int i = 0; i < EntriesPerRow; i++) begin
          cand_q[i] <= cand[i][ColW-1:0];
        end
      end
      default: ;
    endcase
  end

  assign sts_o.out_of_range = {1'b0, cell_q} >= total_q;
  assign sts_o.last         = (valid_q & ~hit) == '0;
  assign column_o           = best;
  assign position_o         = entry_count_q;

  a_pop_has_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OP_POP) |-> (valid_q != '0))
    else $error("pop with no pending column");

  a_count_advances: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OP_POP) |=> (entry_count_q == $past(entry_count_q) + 1'b1))
    else $error("entry count did not advance on pop");

  a_self_present: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OP_BUILD) |=> valid_q[EntriesPerRow-1])
    else $error("row lost its own cell column");

  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OP_DIV_STEP) |-> (rem_q < div_q))
    else $error("divider remainder out of range");

endmodule

// ===== hw/rtl/stencil_csr_column_generator.sv =====
// Top level of the seven-point stencil CSR column generator.
// One cell index is taken per row; the block splits it into x, y and z with a
// shared one-bit-per-cycle divider (24 steps by size_x, then 16 by size_y) and
// then emits the row's 1 to 7 columns in ascending order, one per cycle while
// the sink is ready. The input is ready again right after the last column;
// a cell index outside the grid produces no columns. Configuration is to be
// written through cfg_we_i, cfg_index_i and cfg_data_i only while the block
// is idle; the block itself does not enforce this.
module stencil_csr_column_generator import scc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  scc_in_if.sink              in_ch,
  scc_out_if.source           out_ch
);

  cmd_t cmd;
  sts_t sts;

  scc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_ch.valid),
    .in_ready_o  (in_ch.ready),
    .out_valid_o (out_ch.valid),
    .out_ready_i (out_ch.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  scc_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .cell_index_i (in_ch.cell_index),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .column_o     (out_ch.neighbour_column),
    .position_o   (out_ch.entry_position)
  );

  assign out_ch.row_last = sts.last;

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking bench for the stencil CSR column generator: directed rows, then random phases.
module tb_top;
  import scc_pkg::*;

  localparam int unsigned StallLimit   = 3000;
  localparam int unsigned SettleCycles = 64;
  localparam int unsigned HoldCycles   = 400;
  localparam int unsigned NumPhases    = 6;
  localparam int unsigned PhaseItems   = 76;
  localparam int unsigned PressPhase   = 2;
  localparam int unsigned PlanRows     = 32;
  localparam int unsigned CellSpan     = 1 << ColW;
  localparam int unsigned MaxPrinted   = 50;
  localparam logic [CfgIdxW-1:0] RegSpareA = 3'd6;
  localparam logic [CfgIdxW-1:0] RegSpareB = 3'd7;

  typedef enum logic {ROW_CFG, ROW_CELL} row_kind_e;

  typedef struct packed {
    row_kind_e            kind;
    logic [CfgIdxW-1:0]   idx;
    logic [CfgDataW-1:0]  data;
    logic [ColW-1:0]      cell_id;
    logic                 typed;
    logic [2:0]           n_cols;
    logic [0:6][ColW-1:0] cols;
  } stim_row_t;

  typedef struct packed {
    logic [ColW-1:0] col;
    logic [PosW-1:0] pos;
    logic            last;
  } column_entry_t;

  localparam stim_row_t Plan [PlanRows] = '{
    '{ROW_CELL, REG_SIZE_X, 9'd0, 24'd0, 1'b1, 3'd4,
      '{24'd0, 24'd1, 24'd64, 24'd4096, 24'd0, 24'd0, 24'd0}},
    '{ROW_CELL, REG_SIZE_X, 9'd0, 24'd262143, 1'b1, 3'd4,
      '{24'd258047, 24'd262079, 24'd262142, 24'd262143, 24'd0, 24'd0, 24'd0}},
    '{ROW_CELL, REG_SIZE_X, 9'd0, 24'd262144, 1'b1, 3'd0, '0},
    '{ROW_CELL, REG_SIZE_X, 9'd0, 24'd16777215, 1'b1, 3'd0, '0},
    '{ROW_CELL, REG_SIZE_X, 9'd0, 24'd4161, 1'b1, 3'd7,
      '{24'd65, 24'd4097, 24'd4160, 24'd4161, 24'd4162, 24'd4225, 24'd8257}},
    '{ROW_CFG, REG_PERIODIC_X, 9'd1, 24'd0, 1'b0, 3'd0, '0},
    '{ROW_CFG, REG_PERIODIC_Y, 9'd1, 24'd0, 1'b0, 3'd0, '0},
    '{ROW_CFG, REG_PERIODIC_Z, 9'd1, 24'd0, 1'b0, 3'd0, '0},
    '{ROW_CELL, REG_SIZE_X, 9'd0, 24'd0, 1'b1, 3'd7,
      '{24'd0, 24'd1, 24'd63, 24'd64, 24'd4032, 24'd4096, 24'd258048}},
    '{ROW_CELL, REG_SIZE_X, 9'd0, 24'd262143, 1'b0, 3'd0, '0},
    '{ROW_CFG, REG_SIZE_X, 9'd0, 24'd0, 1'b0, 3'd0, '0},
    '{ROW_CFG, REG_SIZE_Y, 9'd0, 24'd0, 1'b0, 3'd0, '0},
    '{ROW_CFG, REG_SIZE_Z, 9'd0, 24'd0, 1'b0, 3'd0, '0},
    '{ROW_CELL, REG_SIZE_X, 9'd0, 24'd0, 1'b1, 3'd1,
      '{24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0}},
    '{ROW_CELL, REG_SIZE_X, 9'd0, 24'd1, 1'b1, 3'd0, '0},
    '{ROW_CFG, REG_SIZE_X, 9'd511, 24'd0, 1'b0, 3'd0, '0},
    '{ROW_CFG, REG_SIZE_Y, 9'd256, 24'd0, 1'b0, 3'd0, '0},
    '{ROW_CFG, REG_SIZE_Z, 9'd256, 24'd0, 1'b0, 3'd0, '0},
    '{ROW_CELL, REG_SIZE_X, 9'd0, 24'd16777215, 1'b1, 3'd7,
      '{24'd65535, 24'd16711679, 24'd16711935, 24'd16776959,
        24'd16776960, 24'd16777214, 24'd16777215}},
    '{ROW_CELL, REG_SIZE_X, 9'd0, 24'd0, 1'b0, 3'd0, '0},
    '{ROW_CFG, REG_SIZE_X, 9'd2, 24'd0, 1'b0, 3'd0, '0},
    '{ROW_CFG, REG_SIZE_Y, 9'd2, 24'd0, 1'b0, 3'd0, '0},
    '{ROW_CFG, REG_SIZE_Z, 9'd2, 24'd0, 1'b0, 3'd0, '0},
    '{ROW_CELL, REG_SIZE_X, 9'd0, 24'd0, 1'b1, 3'd4,
      '{24'd0, 24'd1, 24'd2, 24'd4, 24'd0, 24'd0, 24'd0}},
    '{ROW_CELL, REG_SIZE_X, 9'd0, 24'd7, 1'b0, 3'd0, '0},
    '{ROW_CFG, REG_PERIODIC_X, 9'd0, 24'd0, 1'b0, 3'd0, '0},
    '{ROW_CFG, REG_SIZE_X, 9'd1, 24'd0, 1'b0, 3'd0, '0},
    '{ROW_CFG, REG_SIZE_Y, 9'd3, 24'd0, 1'b0, 3'd0, '0},
    '{ROW_CFG, RegSpareA, 9'd511, 24'd0, 1'b0, 3'd0, '0},
    '{ROW_CFG, RegSpareB, 9'd0, 24'd0, 1'b0, 3'd0, '0},
    '{ROW_CELL, REG_SIZE_X, 9'd0, 24'd5, 1'b0, 3'd0, '0},
    '{ROW_CELL, REG_SIZE_X, 9'd0, 24'd6, 1'b1, 3'd0, '0}
  };

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_data;

  logic [SizeW-1:0] grid_x = 9'd64;
  logic [SizeW-1:0] grid_y = 9'd64;
  logic [SizeW-1:0] grid_z = 9'd64;
  bit               wrap_x = 1'b0;
  bit               wrap_y = 1'b0;
  bit               wrap_z = 1'b0;
  logic [PosW-1:0]  column_count = '0;
  column_entry_t    columns_due[$];

  int unsigned mismatch_count = 0;
  int unsigned idle_cycles = 0;
  bit          source_calm = 1'b0;
  bit          sink_calm = 1'b0;
  bit          hold_sink = 1'b0;

  scc_in_if  in_ch ();
  scc_out_if out_ch ();

  stencil_csr_column_generator uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .in_ch       (in_ch),
    .out_ch      (out_ch)
  );

  always #10 clk_i = ~clk_i;

  function automatic int unsigned clamp_dim(input logic [SizeW-1:0] s);
    if (s == '0) return 1;
    if (s > MaxDim) return MaxDim;
    return 32'(s);
  endfunction

  function automatic bit step_axis(input int unsigned c, input bit up, input int unsigned n,
                                   input bit wrap, output int unsigned r);
    bit ok;
    ok = 1'b1;
    r = 0;
    if (!up) begin
      if (c == 0) begin
        ok = wrap;
        r = n - 1;
      end else begin
        r = c - 1;
      end
    end else begin
      if (c + 1 >= n) begin
        ok = wrap;
        r = 0;
      end else begin
        r = c + 1;
      end
    end
    return ok;
  endfunction

  function automatic void push_column(input logic [ColW-1:0] col, input logic last);
    column_entry_t e;
    e.col = col;
    e.pos = column_count;
    e.last = last;
    columns_due.insert(columns_due.size(), e);
    column_count = column_count + 1'b1;
  endfunction

  // Collect the stencil columns of one row, sort, merge repeats.
  function automatic void build_row_columns(input logic [ColW-1:0] cell_id);
    int unsigned nx, ny, nz, x, y, z, t, c;
    int unsigned cand[$];
    int unsigned uniq[$];
    nx = clamp_dim(grid_x);
    ny = clamp_dim(grid_y);
    nz = clamp_dim(grid_z);
    c = 32'(cell_id);
    if (c >= nx * ny * nz) return;
    x = c % nx;
    y = (c / nx) % ny;
    z = (c / nx) / ny;
    if (step_axis(x, 1'b0, nx, wrap_x, t)) cand.insert(cand.size(), t + nx * (y + ny * z));
    if (step_axis(x, 1'b1, nx, wrap_x, t)) cand.insert(cand.size(), t + nx * (y + ny * z));
    if (step_axis(y, 1'b0, ny, wrap_y, t)) cand.insert(cand.size(), x + nx * (t + ny * z));
    if (step_axis(y, 1'b1, ny, wrap_y, t)) cand.insert(cand.size(), x + nx * (t + ny * z));
    if (step_axis(z, 1'b0, nz, wrap_z, t)) cand.insert(cand.size(), x + nx * (y + ny * t));
    if (step_axis(z, 1'b1, nz, wrap_z, t)) cand.insert(cand.size(), x + nx * (y + ny * t));
    cand.insert(cand.size(), c);
    cand.sort();
    foreach (cand[k]) begin
      if (k == 0 || cand[k] != cand[k-1]) uniq.insert(uniq.size(), cand[k]);
    end
    foreach (uniq[k]) begin
      push_column(ColW'(uniq[k]), k == uniq.size() - 1);
    end
  endfunction

  function automatic int unsigned pick_coord(input int unsigned n);
    case ($urandom_range(0, 3))
      0: return 0;
      1: return n - 1;
      default: return $urandom_range(0, n - 1);
    endcase
  endfunction

  // Bias toward faces and corners; some indices off the grid.
  function automatic logic [ColW-1:0] pick_cell();
    int unsigned nx, ny, nz, span;
    nx = clamp_dim(grid_x);
    ny = clamp_dim(grid_y);
    nz = clamp_dim(grid_z);
    span = nx * ny * nz;
    if (span < CellSpan && $urandom_range(0, 7) == 0) begin
      return ColW'($urandom_range(span, CellSpan - 1));
    end
    return ColW'(pick_coord(nx) + nx * (pick_coord(ny) + ny * pick_coord(nz)));
  endfunction

  function automatic logic [CfgDataW-1:0] pick_size();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return CfgDataW'(1);
      2: return CfgDataW'(2);
      3: return CfgDataW'(MaxDim);
      4: return CfgDataW'($urandom_range(MaxDim + 1, 511));
      5: return CfgDataW'($urandom_range(41, MaxDim - 1));
      default: return CfgDataW'($urandom_range(3, 40));
    endcase
  endfunction

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    mismatch_count++;
    if (mismatch_count <= MaxPrinted) begin
      $display("%t mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    end
  endtask

  task automatic check_column();
    column_entry_t want;
    if (columns_due.size() == 0) begin
      report_mismatch("column with nothing pending", out_ch.neighbour_column, 0);
      return;
    end
    want = columns_due.pop_front();
    if (out_ch.neighbour_column !== want.col) begin
      report_mismatch("neighbour_column", out_ch.neighbour_column, want.col);
    end
    if (out_ch.entry_position !== want.pos) begin
      report_mismatch("entry_position", out_ch.entry_position, want.pos);
    end
    if (out_ch.row_last !== want.last) begin
      report_mismatch("row_last", out_ch.row_last, want.last);
    end
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk_i);
    case (idx)
      REG_SIZE_X:     grid_x = data;
      REG_SIZE_Y:     grid_y = data;
      REG_SIZE_Z:     grid_z = data;
      REG_PERIODIC_X: wrap_x = data[0];
      REG_PERIODIC_Y: wrap_y = data[0];
      REG_PERIODIC_Z: wrap_z = data[0];
      default: ;
    endcase
  endtask

  task automatic send_cell(input logic [ColW-1:0] cell_id);
    int unsigned gap;
    if ($urandom_range(0, 29) == 0) source_calm = !source_calm;
    gap = source_calm ? 0 : $urandom_range(0, 19);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.cell_index <= cell_id;
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  // Drop valid, drain pending columns, then let the block settle.
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (columns_due.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  initial begin
    bit              writing;
    logic [ColW-1:0] cell_id;
    writing = 1'b0;
    rst_ni <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= REG_SIZE_X;
    cfg_data <= '0;
    in_ch.valid <= 1'b0;
    in_ch.cell_index <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int r = 0; r < PlanRows; r++) begin
      if (Plan[r].kind == ROW_CFG) begin
        if (!writing) settle();
        write_reg(Plan[r].idx, Plan[r].data);
        writing = 1'b1;
      end else begin
        if (writing) cfg_we <= 1'b0;
        writing = 1'b0;
        send_cell(Plan[r].cell_id);
        if (Plan[r].typed) begin
          for (int k = 0; k < Plan[r].n_cols; k++) begin
            push_column(Plan[r].cols[k], k == Plan[r].n_cols - 1);
          end
        end else begin
          build_row_columns(Plan[r].cell_id);
        end
      end
    end

    for (int p = 0; p < NumPhases; p++) begin
      settle();
      write_reg(REG_SIZE_X, pick_size());
      write_reg(REG_SIZE_Y, pick_size());
      write_reg(REG_SIZE_Z, pick_size());
      write_reg(REG_PERIODIC_X, CfgDataW'($urandom_range(0, 511)));
      write_reg(REG_PERIODIC_Y, CfgDataW'($urandom_range(0, 511)));
      write_reg(REG_PERIODIC_Z, CfgDataW'($urandom_range(0, 511)));
      cfg_we <= 1'b0;
      if (p == PressPhase) hold_sink = 1'b1;
      for (int i = 0; i < PhaseItems; i++) begin
        cell_id = pick_cell();
        send_cell(cell_id);
        build_row_columns(cell_id);
      end
    end

    settle();
    if (mismatch_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    int unsigned stall;
    out_ch.ready <= 1'b0;
    @(posedge clk_i);
    forever begin
      if (hold_sink) begin
        out_ch.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_sink = 1'b0;
      end
      if ($urandom_range(0, 49) == 0) sink_calm = !sink_calm;
      stall = sink_calm ? 0 : $urandom_range(0, 19);
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!out_ch.valid);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) check_column();
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= StallLimit) begin
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

endmodule
